// File: rtl/lpmd_pkg.sv
package lpmd_pkg;

    // Role of one received byte, as reported on the result channel
    typedef enum logic [2:0] {
        ROLE_HEADER   = 3'd0,
        ROLE_LEN_LO   = 3'd1,
        ROLE_LEN_HI   = 3'd2,
        ROLE_PAYLOAD  = 3'd3,
        ROLE_REJECTED = 3'd4
    } role_t;

    // Deframer phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LEN_LO  = 4'b0010,
        PH_LEN_HI  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;

    // One result item
    typedef struct packed {
        role_t              role;
        logic [BYTE_W-1:0]  header_value;
        logic [LEN_W-1:0]   message_length;
        logic [BYTE_W-1:0]  payload_byte;
        logic [LEN_W-1:0]   payload_index;
        logic               message_done;
    } result_t;

endpackage

// File: rtl/lpmd_core.sv
module lpmd_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        enable,
    input  logic                        accept,
    input  logic [lpmd_pkg::BYTE_W-1:0] data_byte,
    output lpmd_pkg::result_t           result
);

    lpmd_pkg::phase_t             phase_reg,  phase_next;
    logic [lpmd_pkg::BYTE_W-1:0]  header_reg, header_next;
    logic [lpmd_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [lpmd_pkg::LEN_W-1:0]   count_reg,  count_next;
    logic [lpmd_pkg::LEN_W-1:0]   count_inc;
    logic [lpmd_pkg::LEN_W-1:0]   length_full;

    assign count_inc   = count_reg + lpmd_pkg::LEN_W'(1);
    assign length_full = {data_byte, length_reg[lpmd_pkg::BYTE_W-1:0]};

    // Result and next state for the byte on the input
    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        length_next = length_reg;
        count_next  = count_reg;

        result.role           = lpmd_pkg::ROLE_REJECTED;
        result.header_value   = header_reg;
        result.message_length = length_reg;
        result.payload_byte   = '0;
        result.payload_index  = '0;
        result.message_done   = 1'b0;

        if (enable) begin
            unique case (phase_reg)
                lpmd_pkg::PH_HEADER: begin
                    result.role           = lpmd_pkg::ROLE_HEADER;
                    result.header_value   = data_byte;
                    result.message_length = '0;
                    header_next = data_byte;
                    length_next = '0;
                    count_next  = '0;
                    phase_next  = lpmd_pkg::PH_LEN_LO;
                end
                lpmd_pkg::PH_LEN_LO: begin
                    result.role           = lpmd_pkg::ROLE_LEN_LO;
                    result.message_length = '0;
                    length_next = {{(lpmd_pkg::LEN_W-lpmd_pkg::BYTE_W){1'b0}}, data_byte};
                    phase_next  = lpmd_pkg::PH_LEN_HI;
                end
                lpmd_pkg::PH_LEN_HI: begin
                    result.role           = lpmd_pkg::ROLE_LEN_HI;
                    result.message_length = length_full;
                    length_next = length_full;
                    count_next  = '0;
                    // zero length: the message ends here
                    if (length_full == '0) begin
                        result.message_done = 1'b1;
                        phase_next = lpmd_pkg::PH_HEADER;
                    end else begin
                        phase_next = lpmd_pkg::PH_PAYLOAD;
                    end
                end
                lpmd_pkg::PH_PAYLOAD: begin
                    result.role          = lpmd_pkg::ROLE_PAYLOAD;
                    result.payload_byte  = data_byte;
                    result.payload_index = count_reg;
                    count_next = count_inc;
                    if (count_inc == length_reg) begin
                        result.message_done = 1'b1;
                        phase_next = lpmd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    phase_next = lpmd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // State advances only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lpmd_pkg::PH_HEADER;
            header_reg <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/length_prefixed_message_deframer.sv
// Length-prefixed message deframer.
// Input stream (s_axis_*): one received byte per request. Messages are one
// header byte, a 16-bit little-endian length, then that many payload bytes.
// Output stream (m_axis_*): one result per input byte. tuser carries the
// byte's role, tlast marks the byte that completes a message, and tdata
// carries header, length, payload byte and payload index.
// Configuration: cfg_wr_en/cfg_wr_data write the enable bit; write it only
// while the block is idle. With enable low every byte is reported as
// rejected and the deframing state is kept.
// Each result is registered, in the output or skid register, on acceptance.
// Throughput: one byte per cycle while s_axis_tready is high; the update of
// phase/length/count is a single registered step, so bytes need no gap.
// Reset (aresetn low, synchronous): enable cleared, deframer waits for a
// header, output and skid registers empty.
// Stall: an output register plus a one-entry skid register decouple the
// sides; s_axis_tready drops only once both hold a pending result.
module length_prefixed_message_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // enable
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] header_value, [23:8] message_length, [31:24] payload_byte,
    // [47:32] payload_index
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,  // [2:0] role
    output logic        m_axis_tlast   // message_done
);

    logic              enable_reg;
    logic              s_acc, m_acc;
    lpmd_pkg::result_t new_result;
    lpmd_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = out_valid_reg && m_axis_tready;

    // Enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
        end
    end

    lpmd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .accept    (s_acc),
        .data_byte (s_axis_tdata),
        .result    (new_result)
    );

    // Output register with one-entry skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_acc) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_acc) begin
            out_valid_reg <= s_acc;
        end else if (s_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_acc) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_acc) begin
            if (s_acc) begin
                out_reg <= new_result;
            end
        end else if (s_acc) begin
            skid_reg <= new_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.payload_index, out_reg.payload_byte,
                            out_reg.message_length, out_reg.header_value};
    assign m_axis_tuser  = out_reg.role;
    assign m_axis_tlast  = out_reg.message_done;

    // Skid entry only holds data behind a pending output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // Last payload byte carries index length-1
    a_done_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast && m_axis_tuser == lpmd_pkg::ROLE_PAYLOAD)
        |-> (m_axis_tdata[47:32] + 16'd1 == m_axis_tdata[23:8]))
        else $error("message done on wrong payload index");

    // Only the length high byte or a payload byte can end a message
    a_done_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast)
        |-> (m_axis_tuser == lpmd_pkg::ROLE_LEN_HI
             || m_axis_tuser == lpmd_pkg::ROLE_PAYLOAD))
        else $error("message done on a header or length low byte");

    // Zero-length done only when the length is really zero
    a_zero_len_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == lpmd_pkg::ROLE_LEN_HI)
        |-> (m_axis_tlast == (m_axis_tdata[23:8] == 16'd0)))
        else $error("length high byte done mark does not match length");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned STALL_LIMIT = 200;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] header_value, [23:8] message_length, [31:24] payload_byte,
    // [47:32] payload_index
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;            // [2:0] role
    logic        m_axis_tlast;            // message_done

    length_prefixed_message_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // Bytes waiting to be sent and results waiting to be seen
    logic [7:0]         pending_bytes[$];
    lpmd_pkg::result_t  expected_results[$];

    // Deframer state as the bench tracks it
    logic              deframe_enable = 1'b0;
    lpmd_pkg::phase_t  cur_phase      = lpmd_pkg::PH_HEADER;
    logic [7:0]        cur_header     = 8'h00;
    logic [15:0]       cur_length     = 16'h0000;
    logic [15:0]       payload_count  = 16'h0000;

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    bit          byte_taken   = 1'b0;
    bit          calm         = 1'b0;

    // Advance the tracked state by one byte and return the result it causes
    function automatic lpmd_pkg::result_t deframe_byte(input logic [7:0] b);
        lpmd_pkg::result_t r;
        r = '0;
        if (!deframe_enable) begin
            r.role           = lpmd_pkg::ROLE_REJECTED;
            r.message_length = cur_length;
        end else begin
            case (cur_phase)
                lpmd_pkg::PH_HEADER: begin
                    r.role        = lpmd_pkg::ROLE_HEADER;
                    cur_header    = b;
                    cur_length    = '0;
                    payload_count = '0;
                    cur_phase     = lpmd_pkg::PH_LEN_LO;
                end
                lpmd_pkg::PH_LEN_LO: begin
                    r.role     = lpmd_pkg::ROLE_LEN_LO;
                    cur_length = {8'h00, b};
                    cur_phase  = lpmd_pkg::PH_LEN_HI;
                end
                lpmd_pkg::PH_LEN_HI: begin
                    r.role           = lpmd_pkg::ROLE_LEN_HI;
                    cur_length       = {b, cur_length[7:0]};
                    r.message_length = cur_length;
                    payload_count    = '0;
                    // empty payload: the length closes the message
                    if (cur_length == 16'd0) begin
                        r.message_done = 1'b1;
                        cur_phase      = lpmd_pkg::PH_HEADER;
                    end else begin
                        cur_phase = lpmd_pkg::PH_PAYLOAD;
                    end
                end
                default: begin
                    r.role           = lpmd_pkg::ROLE_PAYLOAD;
                    r.message_length = cur_length;
                    r.payload_byte   = b;
                    r.payload_index  = payload_count;
                    payload_count    = payload_count + 16'd1;
                    if (payload_count == cur_length) begin
                        r.message_done = 1'b1;
                        cur_phase      = lpmd_pkg::PH_HEADER;
                    end
                end
            endcase
        end
        r.header_value = cur_header;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Driver: requests and sink stalls change at the falling edge
    always @(negedge aclk) begin
        // a request already offered stays put until taken
        if (!(s_axis_tvalid && !byte_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes[0];
                if (!calm && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 13);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        byte_taken = 1'b0;

        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                sink_gap = $urandom_range(1, 13);
        end
    end

    // Monitor: input requests feed the prediction, results are checked in order
    always @(posedge aclk) begin
        lpmd_pkg::result_t want;
        lpmd_pkg::result_t got;
        bit                moved;
        moved = 1'b0;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(deframe_byte(s_axis_tdata));
            void'(pending_bytes.pop_front());
            byte_taken = 1'b1;
            moved      = 1'b1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            got.role           = lpmd_pkg::role_t'(m_axis_tuser);
            got.header_value   = m_axis_tdata[7:0];
            got.message_length = m_axis_tdata[23:8];
            got.payload_byte   = m_axis_tdata[31:24];
            got.payload_index  = m_axis_tdata[47:32];
            got.message_done   = m_axis_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("role", want.role, got.role);
                check_field("header_value", want.header_value, got.header_value);
                check_field("message_length", want.message_length,
                            got.message_length);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("payload_index", want.payload_index,
                            got.payload_index);
                check_field("message_done", want.message_done, got.message_done);
            end
        end
        // watchdog on a stuck handshake
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_enable(input logic value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= value;
        deframe_enable  = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Header, little-endian length, then random payload
    task automatic queue_message(input logic [7:0] hdr, input logic [15:0] len);
        pending_bytes.push_back(hdr);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(len[15:8]);
        for (int unsigned i = 0; i < len; i++)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned deframed;
        int unsigned n;
        logic [15:0] len;
        deframed = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // out of reset the block rejects everything
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h5A);

        set_enable(1'b1);
        // empty payload, closed by the length byte
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h00);
        // single payload byte
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hA5);
        pending_bytes.push_back(8'h02);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h80);
        // stop between the two length bytes
        pending_bytes.push_back(8'h3C);
        pending_bytes.push_back(8'h01);

        set_enable(1'b0);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'hAA);

        set_enable(1'b1);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h7F);
        // stop inside a payload
        pending_bytes.push_back(8'h5A);
        pending_bytes.push_back(8'h03);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h11);

        set_enable(1'b0);
        pending_bytes.push_back(8'h22);

        set_enable(1'b1);
        pending_bytes.push_back(8'h33);
        pending_bytes.push_back(8'h44);

        // long message with a nonzero length high byte
        queue_message(8'hC3, 16'h0101);

        // random traffic, phases split by enable writes
        while (deframed < 80) begin
            if ($urandom_range(0, 3) == 0) begin
                set_enable(1'b0);
                n = $urandom_range(1, 6);
                repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                set_enable(1'b1);
                n = pending_bytes.size();
                repeat ($urandom_range(1, 4)) begin
                    len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 300))
                                                      : 16'($urandom_range(0, 8));
                    queue_message(8'($urandom_range(0, 255)), len);
                end
                // sometimes leave a broken message behind
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        pending_bytes.push_back(8'($urandom_range(0, 255)));
                deframed += pending_bytes.size() - n;
            end
        end

        // final stretch at full rate on both sides
        set_enable(1'b1);
        calm = 1'b1;
        repeat (6) queue_message(8'($urandom_range(0, 255)), 16'($urandom_range(0, 8)));

        wait_drained();
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
